FILE: hw/rtl/via_pkg.sv
// shared types, codes and helper functions of the interface adapter
// no dependencies; used by via_core and versatile_interface_adapter
package via_pkg;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_TICK  = 3'd2,
    OP_PINS_A = 3'd3,
    OP_PINS_B = 3'd4,
    OP_LINE  = 3'd5
  } op_t;

  localparam logic [3:0] R_ORB  = 4'd0;
  localparam logic [3:0] R_ORA  = 4'd1;
  localparam logic [3:0] R_DDRB = 4'd2;
  localparam logic [3:0] R_DDRA = 4'd3;
  localparam logic [3:0] R_T1CL = 4'd4;
  localparam logic [3:0] R_T1CH = 4'd5;
  localparam logic [3:0] R_T1LL = 4'd6;
  localparam logic [3:0] R_T1LH = 4'd7;
  localparam logic [3:0] R_T2CL = 4'd8;
  localparam logic [3:0] R_T2CH = 4'd9;
  localparam logic [3:0] R_SR   = 4'd10;
  localparam logic [3:0] R_ACR  = 4'd11;
  localparam logic [3:0] R_PCR  = 4'd12;
  localparam logic [3:0] R_IFR  = 4'd13;
  localparam logic [3:0] R_IER  = 4'd14;

  localparam logic [7:0] F_CA2 = 8'h01;
  localparam logic [7:0] F_CA1 = 8'h02;
  localparam logic [7:0] F_SR  = 8'h04;
  localparam logic [7:0] F_CB2 = 8'h08;
  localparam logic [7:0] F_CB1 = 8'h10;
  localparam logic [7:0] F_T2  = 8'h20;
  localparam logic [7:0] F_T1  = 8'h40;

  // line_levels bit positions
  localparam int L_CA1 = 0;
  localparam int L_CA2 = 1;
  localparam int L_CB1 = 2;
  localparam int L_CB2 = 3;

  // timer_flags bit positions
  localparam int TF_T1RELOAD = 0;
  localparam int TF_T1RUN    = 1;
  localparam int TF_T2RELOAD = 2;
  localparam int TF_T2RUN    = 3;

  // shift modes, ACR bits 4..2
  localparam logic [2:0] SM_FREE = 3'b100;
  localparam logic [2:0] SM_T2   = 3'b101;
  localparam logic [2:0] SM_CLK  = 3'b110;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] reg_offset;
    logic [7:0] data;
    logic [7:0] pin_mask;
    logic [1:0] line_select;
    logic       tick_count;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       ca2_out;
    logic       cb1_out;
    logic       cb2_out;
  } result_t;

  typedef struct packed {
    logic [7:0]  out_reg_a;
    logic [7:0]  out_reg_b;
    logic [7:0]  dir_a;
    logic [7:0]  dir_b;
    logic [7:0]  in_pins_a;
    logic [7:0]  in_pins_b;
    logic [7:0]  in_latch_a;
    logic [7:0]  in_latch_b;
    logic [15:0] timer1_latch;
    logic [15:0] timer1_count;
    logic [15:0] timer2_latch;
    logic [15:0] timer2_count;
    logic [3:0]  timer_flags;
    logic [7:0]  shift_reg;
    logic [3:0]  shift_count;
    logic [9:0]  shift_timer;
    logic        shift_armed;
    logic [7:0]  aux_control;
    logic [7:0]  periph_control;
    logic [7:0]  int_flags;
    logic [6:0]  int_enable;
    logic [3:0]  line_levels;
    logic [1:0]  pulse_pending;
  } state_t;

  // clearing a CA1 or CB1 flag reloads its input latch
  function automatic state_t drop_flag(state_t s, logic [7:0] bits);
    state_t r;
    r = s;
    if ((bits & F_CA1) != 8'h00) r.in_latch_a = r.in_pins_a;
    if ((bits & F_CB1) != 8'h00) r.in_latch_b = r.in_pins_b;
    r.int_flags = r.int_flags & ~bits;
    return r;
  endfunction

  function automatic state_t shift_one(state_t s);
    state_t r;
    r = s;
    r.line_levels[L_CB2] = s.shift_reg[7];
    r.shift_reg = {s.shift_reg[6:0], s.shift_reg[7]};
    return r;
  endfunction

endpackage

FILE: hw/rtl/versatile_interface_adapter.sv
// 6522-style interface adapter: ports, timers, shift register, interrupts
// depends on via_pkg and via_core
//
// usage: each item on the s_ channel is a bus write or read of one of the
// sixteen registers, a one-cycle tick, a write of external port pins or a
// new level on CA1, CA2, CB1 or CB2. every item gives exactly one item on
// the m_ channel carrying the read data, the interrupt request, both port
// output values and the CA2, CB1 and CB2 levels.
// the state moves on at the accepting edge and its result sits in the output
// register from the next cycle; one item per cycle is sustained while the
// receiver takes each result. the whole register update is a single pass of
// logic between the accepting edge and the state and output registers.
// when the receiver stalls, the held result stays on m_tdata and a new item
// is taken only in a cycle where that result is being taken.
// reset clears every state register, the flags and the output valid; the
// held result register keeps its contents until the next item
module versatile_interface_adapter import via_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // reg_offset[3:0], data[11:4], pin_mask[19:12], tick_count[20], zero fill
  input  logic [23:0] s_tdata,
  // op[2:0], line_select[4:3]
  input  logic [4:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], irq[8], port_a_out[16:9], port_b_out[24:17],
  // ca2_out[25], cb1_out[26], cb2_out[27], zero fill
  output logic [31:0] m_tdata
);

  item_t   item;
  result_t result_next;
  result_t result;
  logic    take;

  assign s_tready = !m_tvalid || m_tready;
  assign take = s_tvalid && s_tready;

  assign item.op          = s_tuser[2:0];
  assign item.line_select = s_tuser[4:3];
  assign item.reg_offset  = s_tdata[3:0];
  assign item.data        = s_tdata[11:4];
  assign item.pin_mask    = s_tdata[19:12];
  assign item.tick_count  = s_tdata[20];

  via_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (item),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign m_tdata = {4'b0000, result.cb2_out, result.cb1_out, result.ca2_out,
                    result.port_b_out, result.port_a_out, result.irq,
                    result.read_data};

endmodule

FILE: hw/rtl/via_core.sv
// register file, timers, shift register and interrupt logic of the adapter
// depends on via_pkg; state moves on once per accepted item
module via_core import via_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  item_t   item,
  output result_t result_next
);

  state_t st;
  state_t s;
  logic [7:0] rd;
  logic signed [10:0] t;
  logic signed [10:0] n;
  logic done;
  logic old6;
  logic lvl_old;
  logic rising;
  logic [2:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= s;
    end
  end

  always_comb begin
    s = st;
    rd = 8'h00;
    t = '0;
    n = '0;
    done = 1'b0;
    old6 = 1'b0;
    lvl_old = 1'b0;
    rising = 1'b0;
    mode = st.aux_control[4:2];
    case (item.op)
      OP_WRITE: begin
        case (item.reg_offset)
          R_ORB, R_ORA: begin
            if (item.reg_offset == R_ORB) begin
              s.out_reg_b = item.data;
              s = drop_flag(s, F_CB1);
              case (s.periph_control[7:5])
                3'b000, 3'b010: s = drop_flag(s, F_CB2);
                3'b101: begin
                  s.pulse_pending[1] = 1'b1;
                  s.line_levels[L_CB2] = 1'b0;
                end
                3'b100: s.line_levels[L_CB2] = 1'b0;
                default: ;
              endcase
            end else begin
              s.out_reg_a = item.data;
              s = drop_flag(s, F_CA1);
              case (s.periph_control[3:1])
                3'b000, 3'b010: s = drop_flag(s, F_CA2);
                3'b101: begin
                  s.pulse_pending[0] = 1'b1;
                  s.line_levels[L_CA2] = 1'b0;
                end
                3'b100: s.line_levels[L_CA2] = 1'b0;
                default: ;
              endcase
            end
          end
          R_DDRB: s.dir_b = item.data;
          R_DDRA: s.dir_a = item.data;
          R_T1CL, R_T1LL: s.timer1_latch[7:0] = item.data;
          R_T1CH: begin
            s.timer1_latch[15:8] = item.data;
            s.timer1_count = s.timer1_latch;
            s.timer_flags[TF_T1RELOAD] = 1'b1;
            s.timer_flags[TF_T1RUN] = 1'b1;
            s = drop_flag(s, F_T1);
            if (s.aux_control[7:6] == 2'b10) s.out_reg_b[7] = 1'b0;
          end
          R_T1LH: begin
            s.timer1_latch[15:8] = item.data;
            s = drop_flag(s, F_T1);
          end
          R_T2CL: s.timer2_latch[7:0] = item.data;
          R_T2CH: begin
            s.timer2_latch[15:8] = item.data;
            s.timer2_count = s.timer2_latch;
            s.timer_flags[TF_T2RELOAD] = 1'b1;
            s.timer_flags[TF_T2RUN] = 1'b1;
            s = drop_flag(s, F_T2);
          end
          R_SR: begin
            s.shift_reg = item.data;
            s.shift_count = 4'd0;
            s.shift_timer = 10'd0;
            s.shift_armed = 1'b1;
            s = drop_flag(s, F_SR);
          end
          R_ACR: begin
            s.aux_control = item.data;
            if (!item.data[6]) s.timer_flags[TF_T1RELOAD] = 1'b0;
          end
          R_PCR: begin
            s.periph_control = item.data;
            if (item.data[3:1] == 3'b110) begin
              s.line_levels[L_CA2] = 1'b0;
              s.pulse_pending[0] = 1'b0;
            end else if (item.data[3:1] == 3'b111) begin
              s.line_levels[L_CA2] = 1'b1;
            end
            if (item.data[7:5] == 3'b110) begin
              s.line_levels[L_CB2] = 1'b0;
              s.pulse_pending[1] = 1'b0;
            end else if (item.data[7:5] == 3'b111) begin
              s.line_levels[L_CB2] = 1'b1;
            end
          end
          R_IFR: s = drop_flag(s, {1'b0, item.data[6:0]});
          R_IER: begin
            if (item.data[7]) s.int_enable = s.int_enable | item.data[6:0];
            else s.int_enable = s.int_enable & ~item.data[6:0];
          end
          default: s.out_reg_a = item.data;
        endcase
      end
      OP_READ: begin
        case (item.reg_offset)
          R_ORB: begin
            s = drop_flag(s, F_CB1);
            case (s.periph_control[7:5])
              3'b000, 3'b010: s = drop_flag(s, F_CB2);
              3'b101: begin
                s.pulse_pending[1] = 1'b1;
                s.line_levels[L_CB2] = 1'b0;
              end
              3'b100: s.line_levels[L_CB2] = 1'b0;
              default: ;
            endcase
            rd = (s.out_reg_b & s.dir_b) | (s.in_latch_b & ~s.dir_b);
          end
          R_ORA: begin
            s = drop_flag(s, F_CA1);
            case (s.periph_control[3:1])
              3'b000, 3'b010: s = drop_flag(s, F_CA2);
              3'b101: begin
                s.pulse_pending[0] = 1'b1;
                s.line_levels[L_CA2] = 1'b0;
              end
              3'b100: s.line_levels[L_CA2] = 1'b0;
              default: ;
            endcase
            rd = (s.out_reg_a & s.dir_a) | (s.in_latch_a & ~s.dir_a);
          end
          R_DDRB: rd = s.dir_b;
          R_DDRA: rd = s.dir_a;
          R_T1CL: begin
            s = drop_flag(s, F_T1);
            rd = s.timer1_count[7:0];
          end
          R_T1CH: rd = s.timer1_count[15:8];
          R_T1LL: rd = s.timer1_latch[7:0];
          R_T1LH: rd = s.timer1_latch[15:8];
          R_T2CL: begin
            s = drop_flag(s, F_T2);
            rd = s.timer2_count[7:0];
          end
          R_T2CH: rd = s.timer2_count[15:8];
          R_SR: begin
            s.shift_count = 4'd0;
            s.shift_timer = 10'd0;
            s.shift_armed = 1'b1;
            s = drop_flag(s, F_SR);
            rd = s.shift_reg;
          end
          R_ACR: rd = s.aux_control;
          R_PCR: rd = s.periph_control;
          R_IFR: rd = s.int_flags;
          R_IER: rd = {1'b1, s.int_enable};
          default: rd = (s.out_reg_a & s.dir_a) | (s.in_latch_a & ~s.dir_a);
        endcase
      end
      OP_TICK: begin
        if (item.tick_count) begin
          if (s.pulse_pending[0]) s.line_levels[L_CA2] = 1'b1;
          if (s.pulse_pending[1]) s.line_levels[L_CB2] = 1'b1;
          s.pulse_pending = 2'b00;

          // timer 1: one-shot or free-running with reload cycle
          if (!s.aux_control[6]) begin
            if (s.timer_flags[TF_T1RUN] && s.timer1_count == 16'h0000) begin
              s.int_flags = s.int_flags | F_T1;
              if (s.aux_control[7]) s.out_reg_b[7] = 1'b1;
              s.timer_flags[TF_T1RUN] = 1'b0;
            end
            s.timer1_count = s.timer1_count - 16'd1;
          end else if (s.timer_flags[TF_T1RELOAD]) begin
            s.timer1_count = s.timer1_latch;
            s.timer_flags[TF_T1RELOAD] = 1'b0;
          end else if (s.timer1_count == 16'h0000) begin
            s.timer1_count = 16'hffff;
            s.int_flags = s.int_flags | F_T1;
            if (s.aux_control[7]) s.out_reg_b[7] = ~s.out_reg_b[7];
            s.timer_flags[TF_T1RELOAD] = 1'b1;
          end else begin
            s.timer1_count = s.timer1_count - 16'd1;
          end

          // timer 2 in one-shot mode
          if (!s.aux_control[5]) begin
            if (s.timer_flags[TF_T2RELOAD]) begin
              s.timer_flags[TF_T2RELOAD] = 1'b0;
            end else begin
              if (s.timer_flags[TF_T2RUN] && s.timer2_count == 16'h0000) begin
                s.int_flags = s.int_flags | F_T2;
                s.timer_flags[TF_T2RUN] = 1'b0;
              end
              s.timer2_count = s.timer2_count - 16'd1;
            end
          end

          if (mode == SM_FREE || mode == SM_T2) begin
            if (s.shift_armed && !(mode == SM_T2 && s.shift_count == 4'd8)) begin
              t = $signed({1'b0, s.shift_timer}) - 11'sd1;
              n = $signed({3'b000, s.timer2_latch[7:0]}) + 11'sd1;
              // at most two half periods of the shift clock fit in one cycle
              for (int i = 0; i < 2; i++) begin
                if (!done && t <= 11'sd0) begin
                  t = t + n;
                  s.line_levels[L_CB1] = ~s.line_levels[L_CB1];
                  if (!s.line_levels[L_CB1]) begin
                    s = shift_one(s);
                    if (mode == SM_FREE) begin
                      s.shift_count = {1'b0, s.shift_count[2:0] + 3'd1};
                    end else begin
                      s.shift_count = s.shift_count + 4'd1;
                      if (s.shift_count == 4'd8) begin
                        s.int_flags = s.int_flags | F_SR;
                        t = 11'sd0;
                        s.shift_armed = 1'b0;
                        done = 1'b1;
                      end
                    end
                  end
                end
              end
              s.shift_timer = t[9:0];
            end
          end else if (mode == SM_CLK) begin
            if (s.shift_armed && s.shift_count != 4'd8) begin
              s.line_levels[L_CB1] = ~s.line_levels[L_CB1];
              if (!s.line_levels[L_CB1]) begin
                s = shift_one(s);
                s.shift_count = s.shift_count + 4'd1;
                if (s.shift_count == 4'd8) begin
                  s.int_flags = s.int_flags | F_SR;
                  s.shift_armed = 1'b0;
                end
              end
            end
          end else begin
            s = drop_flag(s, F_SR);
            s.shift_count = 4'd0;
            s.shift_armed = 1'b0;
          end
        end
      end
      OP_PINS_A: begin
        s.in_pins_a = (s.in_pins_a & ~item.pin_mask) | (item.data & item.pin_mask);
        if (!s.aux_control[0] || (s.int_flags & F_CA1) == 8'h00)
          s.in_latch_a = s.in_pins_a;
      end
      OP_PINS_B: begin
        old6 = s.in_pins_b[6];
        s.in_pins_b = (s.in_pins_b & ~item.pin_mask) | (item.data & item.pin_mask);
        if (!s.aux_control[1] || (s.int_flags & F_CB1) == 8'h00)
          s.in_latch_b = s.in_pins_b;
        // timer 2 counts falling edges on PB6
        if (s.aux_control[5] && old6 && !s.in_pins_b[6]) begin
          s.timer2_count = s.timer2_count - 16'd1;
          if (s.timer_flags[TF_T2RUN] && s.timer2_count == 16'h0000) begin
            s.int_flags = s.int_flags | F_T2;
            s.timer_flags[TF_T2RUN] = 1'b0;
          end
        end
      end
      OP_LINE: begin
        case (item.line_select)
          2'd0: begin
            lvl_old = s.line_levels[L_CA1];
            rising = s.periph_control[0];
            if (rising ? (!lvl_old && item.data[0]) : (lvl_old && !item.data[0]))
              s.int_flags = s.int_flags | F_CA1;
            s.line_levels[L_CA1] = item.data[0];
          end
          2'd1: begin
            if (!s.periph_control[3]) begin
              lvl_old = s.line_levels[L_CA2];
              rising = s.periph_control[2];
              if (rising ? (!lvl_old && item.data[0]) : (lvl_old && !item.data[0]))
                s.int_flags = s.int_flags | F_CA2;
              s.line_levels[L_CA2] = item.data[0];
            end
          end
          2'd2: begin
            lvl_old = s.line_levels[L_CB1];
            rising = s.periph_control[4];
            if (rising ? (!lvl_old && item.data[0]) : (lvl_old && !item.data[0]))
              s.int_flags = s.int_flags | F_CB1;
            s.line_levels[L_CB1] = item.data[0];
          end
          default: begin
            if (!s.periph_control[7]) begin
              lvl_old = s.line_levels[L_CB2];
              rising = s.periph_control[6];
              if (rising ? (!lvl_old && item.data[0]) : (lvl_old && !item.data[0]))
                s.int_flags = s.int_flags | F_CB2;
              s.line_levels[L_CB2] = item.data[0];
            end
          end
        endcase
      end
      default: ;
    endcase
    // bit 7 of the flag register is the summary of enabled flags
    s.int_flags[7] = |(s.int_flags[6:0] & s.int_enable);

    result_next.read_data  = rd;
    result_next.irq        = s.int_flags[7];
    result_next.port_a_out = s.out_reg_a & s.dir_a;
    result_next.port_b_out = s.out_reg_b & s.dir_b;
    result_next.ca2_out    = s.line_levels[L_CA2];
    result_next.cb1_out    = s.line_levels[L_CB1];
    result_next.cb2_out    = s.line_levels[L_CB2];
  end

endmodule
